### rtl/dmnb_pkg.sv
// Shared types and constants for the division magic number builder.
// No dependencies; every other file takes names from here by scope.
package dmnb_pkg;

   // Fixed beat field widths
   localparam int FIELD_W = 32;
   localparam int SHIFT_W = 5;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 3;

   // Sideband that rides along with every item through the cell chain
   typedef struct packed {
      logic [SHIFT_W-1:0] shift;
      logic               negative;
      logic               zero_divisor;
      logic               pow2;
   } side_type;

endpackage

### rtl/division_magic_number_builder_top.sv
// Division magic number builder: front end, chain of WIDTH division cells,
// back end. A beat is registered in the front end, each cell and the back
// end on its way to the result beat. Throughput one beat per cycle: each
// cell of the chain retires one quotient bit and passes its item on every
// cycle; the whole chain holds while the result beat waits. Synchronous
// active-high reset clears the valid bits only; there is no clearing pass.
module division_magic_number_builder_top #(
   parameter int WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   // request: tdata = divisor[31:0]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,
   // request: tuser = signed_mode[0]
   input  logic         req_tuser,
   // result: tdata = magic[31:0], shift[36:32], zero fill[39:37]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,
   // result: tuser = add_needed[0], negative[1], zero_divisor[2]
   output logic [2:0]   rsp_tuser
);

   localparam int FW = dmnb_pkg::FIELD_W;
   localparam int SW = dmnb_pkg::SHIFT_W;
   localparam logic [WIDTH-1:0] REM_INIT = {1'b1, {(WIDTH-1){1'b0}}};

   logic                adv;

   // Taps between the cells of the chain
   logic                tap_valid [WIDTH+1];
   logic [WIDTH-1:0]    tap_rem   [WIDTH+1];
   logic [WIDTH-1:0]    tap_quo   [WIDTH+1];
   logic [WIDTH-1:0]    tap_dn    [WIDTH+1];
   dmnb_pkg::side_type  tap_side  [WIDTH+1];

   logic [FW-1:0]       magic;
   logic                add_needed;
   logic [SW-1:0]       shift;
   logic                negative;
   logic                zero_divisor;

   // Advance everything unless the held result beat is stalled
   assign adv        = ~rsp_tvalid | rsp_tready;
   assign req_tready = adv;

   dmnb_front #(.WIDTH(WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_tvalid),
      .divisor     (req_tdata[WIDTH-1:0]),
      .signed_mode (req_tuser),
      .out_valid   (tap_valid[0]),
      .out_dn      (tap_dn[0]),
      .out_side    (tap_side[0])
   );

   // Dividend is 2^(2N-1); its top N bits seed the remainder
   assign tap_rem[0] = REM_INIT;
   assign tap_quo[0] = '0;

   for (genvar k = 0; k < WIDTH; k++) begin : g_cell
      dmnb_cell #(.WIDTH(WIDTH)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (tap_valid[k]),
         .in_rem    (tap_rem[k]),
         .in_quo    (tap_quo[k]),
         .in_dn     (tap_dn[k]),
         .in_side   (tap_side[k]),
         .out_valid (tap_valid[k+1]),
         .out_rem   (tap_rem[k+1]),
         .out_quo   (tap_quo[k+1]),
         .out_dn    (tap_dn[k+1]),
         .out_side  (tap_side[k+1])
      );
   end

   dmnb_back #(.WIDTH(WIDTH)) u_back (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (tap_valid[WIDTH]),
      .in_rem       (tap_rem[WIDTH]),
      .in_quo       (tap_quo[WIDTH]),
      .in_dn        (tap_dn[WIDTH]),
      .in_side      (tap_side[WIDTH]),
      .out_valid    (rsp_tvalid),
      .out_magic    (magic),
      .out_add      (add_needed),
      .out_shift    (shift),
      .out_negative (negative),
      .out_zero     (zero_divisor)
   );

   // Pack the result beat
   assign rsp_tdata = {3'b000, shift, magic};
   assign rsp_tuser = {zero_divisor, negative, add_needed};

endmodule

### rtl/dmnb_front.sv
// Front end: absolute value, bit length and normalisation of the divisor.
// Depends on dmnb_pkg (side_type, SHIFT_W).
module dmnb_front #(
   parameter int WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic [WIDTH-1:0]    divisor,
   input  logic                signed_mode,
   output logic                out_valid,
   output logic [WIDTH-1:0]    out_dn,
   output dmnb_pkg::side_type  out_side
);

   localparam int SW = dmnb_pkg::SHIFT_W;
   localparam logic [WIDTH-1:0] TOP_BIT = {1'b1, {(WIDTH-1){1'b0}}};

   logic               mag_valid_ff;
   logic [WIDTH-1:0]   mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic               zero_ff, zero_in;

   logic               norm_valid_ff;
   logic [WIDTH-1:0]   dn_ff, dn_in;
   dmnb_pkg::side_type side_ff, side_in;

   logic [SW-1:0]      msb_pos;
   logic [SW-1:0]      norm_amt;

   // Take the magnitude of the divisor
   always_comb begin
      neg_in  = signed_mode & divisor[WIDTH-1];
      mag_in  = neg_in ? (~divisor + WIDTH'(1)) : divisor;
      zero_in = (divisor == '0);
   end

   // Find the highest set bit and left-align the magnitude
   always_comb begin
      msb_pos = '0;
      for (int i = 0; i < WIDTH; i++) begin
         if (mag_ff[i]) begin
            msb_pos = SW'(i);
         end
      end
      norm_amt = SW'(WIDTH - 1) - msb_pos;
      dn_in    = mag_ff << norm_amt;
      side_in.shift        = zero_ff ? '0 : msb_pos;
      side_in.negative     = neg_ff;
      side_in.zero_divisor = zero_ff;
      side_in.pow2         = (dn_in == TOP_BIT);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff  <= 1'b0;
         norm_valid_ff <= 1'b0;
      end else if (adv) begin
         mag_valid_ff  <= in_valid;
         norm_valid_ff <= mag_valid_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff  <= mag_in;
         neg_ff  <= neg_in;
         zero_ff <= zero_in;
         dn_ff   <= dn_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = norm_valid_ff;
   assign out_dn    = dn_ff;
   assign out_side  = side_ff;

endmodule

### rtl/dmnb_cell.sv
// One restoring division step: one quotient bit per cell, registered.
// Depends on dmnb_pkg (side_type).
module dmnb_cell #(
   parameter int WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic [WIDTH-1:0]    in_rem,
   input  logic [WIDTH-1:0]    in_quo,
   input  logic [WIDTH-1:0]    in_dn,
   input  dmnb_pkg::side_type  in_side,
   output logic                out_valid,
   output logic [WIDTH-1:0]    out_rem,
   output logic [WIDTH-1:0]    out_quo,
   output logic [WIDTH-1:0]    out_dn,
   output dmnb_pkg::side_type  out_side
);

   logic               valid_ff;
   logic [WIDTH-1:0]   rem_ff, rem_in;
   logic [WIDTH-1:0]   quo_ff, quo_in;
   logic [WIDTH-1:0]   dn_ff;
   dmnb_pkg::side_type side_ff;

   logic [WIDTH:0]     trial;
   logic [WIDTH:0]     diff;
   logic               qbit;

   // Shift in a zero dividend bit and subtract where it fits
   always_comb begin
      trial  = {in_rem, 1'b0};
      diff   = trial - {1'b0, in_dn};
      qbit   = (trial >= {1'b0, in_dn});
      rem_in = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      quo_in = {in_quo[WIDTH-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         dn_ff   <= in_dn;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_dn    = dn_ff;
   assign out_side  = side_ff;

endmodule

### rtl/dmnb_back.sv
// Back end: picks magic and add flag from quotient and remainder, holds
// the result beat. Depends on dmnb_pkg (side_type, FIELD_W, SHIFT_W).
module dmnb_back #(
   parameter int WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [WIDTH-1:0]              in_rem,
   input  logic [WIDTH-1:0]              in_quo,
   input  logic [WIDTH-1:0]              in_dn,
   input  dmnb_pkg::side_type            in_side,
   output logic                          out_valid,
   output logic [dmnb_pkg::FIELD_W-1:0]  out_magic,
   output logic                          out_add,
   output logic [dmnb_pkg::SHIFT_W-1:0]  out_shift,
   output logic                          out_negative,
   output logic                          out_zero
);

   localparam int FW = dmnb_pkg::FIELD_W;
   localparam logic [WIDTH-1:0] HALF = {1'b1, {(WIDTH-1){1'b0}}};

   logic                         valid_ff;
   logic [FW-1:0]                magic_ff, magic_in;
   logic                         add_ff, add_in;
   logic [dmnb_pkg::SHIFT_W-1:0] shift_ff, shift_in;
   logic                         neg_ff, neg_in;
   logic                         zero_ff, zero_in;

   logic [WIDTH-1:0]             resid;
   logic                         round_up;
   logic [WIDTH-1:0]             quo_adj;

   // (t+1)*d mod 2^N equals d minus the true remainder; compare it scaled
   always_comb begin
      resid    = in_dn - in_rem;
      round_up = (resid <= HALF);
      quo_adj  = in_quo + {{(WIDTH-1){1'b0}}, round_up};
      zero_in  = in_side.zero_divisor;
      if (in_side.zero_divisor) begin
         magic_in = '0;
         add_in   = 1'b0;
         shift_in = '0;
         neg_in   = 1'b0;
      end else if (in_side.pow2) begin
         magic_in = FW'({WIDTH{1'b1}});
         add_in   = 1'b1;
         shift_in = in_side.shift;
         neg_in   = in_side.negative;
      end else begin
         magic_in = FW'(quo_adj);
         add_in   = ~round_up;
         shift_in = in_side.shift;
         neg_in   = in_side.negative;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         magic_ff <= magic_in;
         add_ff   <= add_in;
         shift_ff <= shift_in;
         neg_ff   <= neg_in;
         zero_ff  <= zero_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_magic    = magic_ff;
   assign out_add      = add_ff;
   assign out_shift    = shift_ff;
   assign out_negative = neg_ff;
   assign out_zero     = zero_ff;

endmodule
